[rtl/lacmc_pkg.sv]
package lacmc_pkg;

  localparam int unsigned MvW  = 15;
  localparam int unsigned CurW = 11;
  localparam int unsigned MeasW = 12;
  localparam int unsigned TickW = 8;
  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [3:0] {
    MODE_BOOT    = 4'd0,
    MODE_HOLDOFF = 4'd1,
    MODE_TOP     = 4'd2,
    MODE_FLOAT   = 4'd3,
    MODE_INUSE   = 4'd4,
    MODE_EMPTY   = 4'd5,
    MODE_DISC    = 4'd6,
    MODE_MAYBE   = 4'd7,
    MODE_FAULTY  = 4'd8,
    MODE_MONITOR = 4'd9
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOP_V      = 4'd0,
    CFG_FLOAT_V    = 4'd1,
    CFG_EMPTY_V    = 4'd2,
    CFG_FAULTY_V   = 4'd3,
    CFG_NEED_TOP_V = 4'd4,
    CFG_CHARGE_I   = 4'd5,
    CFG_FINISH_I   = 4'd6,
    CFG_SETTLE     = 4'd7
  } cfg_idx_e;

  // register reset values
  localparam logic [MvW-1:0]   RstTopMv     = 15'd14400;
  localparam logic [MvW-1:0]   RstFloatMv   = 15'd13800;
  localparam logic [MvW-1:0]   RstEmptyMv   = 15'd11500;
  localparam logic [MvW-1:0]   RstFaultyMv  = 15'd10500;
  localparam logic [MvW-1:0]   RstNeedTopMv = 15'd12600;
  localparam logic [CurW-1:0]  RstChargeMa  = 11'd360;
  localparam logic [MeasW-1:0] RstFinishMa  = 12'd60;
  localparam logic [TickW-1:0] RstSettle    = 8'd5;

  // fixed thresholds
  localparam logic [MvW-1:0]   OffMv      = 15'd100;
  localparam logic [MvW-1:0]   DiscMv     = 15'd1000;
  localparam logic [MvW:0]     InMarginMv = 16'd500;
  localparam logic [MeasW-1:0] MinMa      = 12'd20;
  localparam logic [CurW-1:0]  MaxChgMa   = 11'd2000;
  localparam logic [CurW-1:0]  RstCurMa   = 11'd100;

  typedef struct packed {
    logic [MvW-1:0]   top_mv;
    logic [MvW-1:0]   float_mv;
    logic [MvW-1:0]   empty_mv;
    logic [MvW-1:0]   faulty_mv;
    logic [MvW-1:0]   need_top_mv;
    logic [CurW-1:0]  charge_ma;
    logic [MeasW-1:0] finish_ma;
    logic [TickW-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    mode_e          mode;
    logic           enable;
    logic [MvW-1:0] volt_mv;
    logic [CurW-1:0] cur_ma;
    logic           waiting;
  } result_t;

endpackage

[rtl/lacmc_cfg_regs.sv]
module lacmc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lacmc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lacmc_pkg::MvW-1:0]     cfg_wdata_i,
  output lacmc_pkg::cfg_t               cfg_o
);
  import lacmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOP_V:      cfg_d.top_mv       = cfg_wdata_i;
        CFG_FLOAT_V:    cfg_d.float_mv     = cfg_wdata_i;
        CFG_EMPTY_V:    cfg_d.empty_mv     = cfg_wdata_i;
        CFG_FAULTY_V:   cfg_d.faulty_mv    = cfg_wdata_i;
        CFG_NEED_TOP_V: cfg_d.need_top_mv  = cfg_wdata_i;
        CFG_CHARGE_I:   cfg_d.charge_ma    = cfg_wdata_i[CurW-1:0];
        CFG_FINISH_I:   cfg_d.finish_ma    = cfg_wdata_i[MeasW-1:0];
        CFG_SETTLE:     cfg_d.settle_ticks = cfg_wdata_i[TickW-1:0];
        default:        cfg_d = cfg_q;  // out-of-range index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_mv       <= RstTopMv;
      cfg_q.float_mv     <= RstFloatMv;
      cfg_q.empty_mv     <= RstEmptyMv;
      cfg_q.faulty_mv    <= RstFaultyMv;
      cfg_q.need_top_mv  <= RstNeedTopMv;
      cfg_q.charge_ma    <= RstChargeMa;
      cfg_q.finish_ma    <= RstFinishMa;
      cfg_q.settle_ticks <= RstSettle;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/lacmc_mode_core.sv]
module lacmc_mode_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [lacmc_pkg::MvW-1:0]   vin_i,
  input  logic [lacmc_pkg::MvW-1:0]   bat_i,
  input  logic [lacmc_pkg::MeasW-1:0] cur_i,
  input  lacmc_pkg::cfg_t             cfg_i,
  output lacmc_pkg::result_t          res_o
);
  import lacmc_pkg::*;

  mode_e            mode_q, mode_d;
  logic [TickW-1:0] settle_q, settle_d;
  logic             top_st_q, top_st_d;
  logic             flt_st_q, flt_st_d;
  logic [MvW-1:0]   volt_q, volt_d;
  logic [CurW-1:0]  curc_q, curc_d;
  logic             en_q, en_d;
  logic             waited;

  always_comb begin
    logic [MeasW-1:0] cur;
    logic             disc, susp, fault_hit, fault_wait, done;
    mode_e            fault_mode, mw;

    cur = (cur_i < MinMa) ? '0 : cur_i;

    disc       = bat_i < DiscMv;
    susp       = bat_i < cfg_i.faulty_mv;
    fault_hit  = disc || susp;
    fault_wait = !disc && (mode_q != MODE_FAULTY) && (mode_q != MODE_MAYBE);
    fault_mode = disc ? MODE_DISC : (fault_wait ? MODE_MAYBE : MODE_FAULTY);

    mode_d   = mode_q;
    settle_d = settle_q;
    top_st_d = top_st_q;
    flt_st_d = flt_st_q;
    volt_d   = volt_q;
    curc_d   = curc_q;
    en_d     = en_q;
    waited   = 1'b0;
    done     = 1'b0;
    mw       = mode_q;

    if (settle_q != '0) begin
      settle_d = settle_q - 8'd1;
      waited   = 1'b1;
    end else if ({1'b0, vin_i} < ({1'b0, bat_i} + InMarginMv)) begin
      // supply too low: run from battery
      volt_d = OffMv;
      if (fault_hit) begin
        en_d   = 1'b0;
        mode_d = fault_mode;
        if (fault_wait) settle_d = cfg_i.settle_ticks;
      end else if (bat_i < cfg_i.empty_mv || mode_q == MODE_EMPTY) begin
        en_d   = 1'b0;
        mode_d = MODE_EMPTY;
      end else begin
        en_d   = 1'b1;
        mode_d = MODE_INUSE;
      end
    end else begin
      if (mode_q == MODE_MONITOR && !fault_hit && bat_i >= cfg_i.need_top_mv) begin
        done = 1'b1;  // battery still full, keep monitoring
      end
      if (!done && mode_q != MODE_TOP && mode_q != MODE_FLOAT) begin
        if (fault_hit) begin
          en_d   = 1'b0;
          mode_d = fault_mode;
          if (fault_wait) settle_d = cfg_i.settle_ticks;
          done   = 1'b1;
        end else if (mode_q != MODE_BOOT && mode_q != MODE_HOLDOFF) begin
          settle_d = cfg_i.settle_ticks;
          mode_d   = MODE_HOLDOFF;
          done     = 1'b1;
        end else begin
          top_st_d = 1'b0;
          flt_st_d = 1'b0;
          mw       = (bat_i < cfg_i.need_top_mv) ? MODE_TOP : MODE_FLOAT;
          mode_d   = mw;
        end
      end
      if (!done) begin
        curc_d = (cfg_i.charge_ma > MaxChgMa) ? MaxChgMa : cfg_i.charge_ma;
        if (mw == MODE_TOP) begin
          volt_d = cfg_i.top_mv;
          if (!top_st_d) begin
            top_st_d = 1'b1;
            settle_d = cfg_i.settle_ticks;
            done     = 1'b1;
          end else if (cfg_i.finish_ma > cur) begin
            mode_d = MODE_FLOAT;
          end
        end else if (mw == MODE_FLOAT) begin
          volt_d = cfg_i.float_mv;
          if (!flt_st_d) begin
            flt_st_d = 1'b1;
            settle_d = cfg_i.settle_ticks;
            done     = 1'b1;
          end
        end
      end
      if (!done) begin
        if (cur == '0) begin
          volt_d   = OffMv;
          mode_d   = MODE_MONITOR;
          settle_d = cfg_i.settle_ticks;
        end
        en_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BOOT;
      settle_q <= RstSettle;
      top_st_q <= 1'b0;
      flt_st_q <= 1'b0;
      volt_q   <= OffMv;
      curc_q   <= RstCurMa;
      en_q     <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      settle_q <= settle_d;
      top_st_q <= top_st_d;
      flt_st_q <= flt_st_d;
      volt_q   <= volt_d;
      curc_q   <= curc_d;
      en_q     <= en_d;
    end
  end

  assign res_o.mode    = mode_d;
  assign res_o.enable  = en_d;
  assign res_o.volt_mv = volt_d;
  assign res_o.cur_ma  = curc_d;
  assign res_o.waiting = waited;

endmodule

[rtl/lead_acid_charge_mode_controller_unit.sv]
// Lead-acid charger mode controller.
//
// Input channel (in_valid_i/in_ready_o): one measurement word per one-second
// tick: supply voltage, battery voltage (mV) and charge current (mA).
// Output channel (out_valid_o/out_ready_i): exactly one result word per input
// word: charger mode, load switch enable, buck voltage and current commands,
// and a flag telling whether the tick only ran down the settle countdown.
// Config port: cfg_we_i/cfg_idx_i/cfg_wdata_i write one threshold register
// per cycle; write only while no word is in flight.
//
// Pipeline: an accepted input word enters the input register, then the mode
// logic takes it into the result register. Throughput: one word per cycle while
// the receiver does not stall; the mode update for a word is one compare-and-select
// pass, done in the cycle it moves from the input register to the result register.
//
// Reset: mode boot, settle countdown at 5, buck 100 mV / 100 mA, load off,
// registers at their defaults, both pipeline registers empty.
// Receiver stall: the result word holds; one more word can still sit in the
// input register, after which in_ready_o drops.
module lead_acid_charge_mode_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // measurement words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lacmc_pkg::MvW-1:0]           input_mv_i,
  input  logic [lacmc_pkg::MvW-1:0]           battery_mv_i,
  input  logic [lacmc_pkg::MeasW-1:0]         charge_ma_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [3:0]                          charger_mode_o,
  output logic                                output_enable_o,
  output logic [lacmc_pkg::MvW-1:0]           buck_voltage_mv_o,
  output logic [lacmc_pkg::CurW-1:0]          buck_current_ma_o,
  output logic                                waiting_o,
  // config writes
  input  logic                                cfg_we_i,
  input  logic [lacmc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lacmc_pkg::MvW-1:0]           cfg_wdata_i
);
  import lacmc_pkg::*;

  cfg_t    cfg;
  result_t res;

  // input register
  logic             in_vld_q;
  logic [MvW-1:0]   vin_q, bat_q;
  logic [MeasW-1:0] cur_q;

  // result register
  logic    out_vld_q;
  result_t out_q;

  logic adv;   // result register free to take a new word
  logic step;  // word in input register is processed this cycle

  assign adv        = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;

  lacmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lacmc_mode_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .vin_i  (vin_q),
    .bat_i  (bat_q),
    .cur_i  (cur_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      vin_q <= input_mv_i;
      bat_q <= battery_mv_i;
      cur_q <= charge_ma_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign charger_mode_o    = out_q.mode;
  assign output_enable_o   = out_q.enable;
  assign buck_voltage_mv_o = out_q.volt_mv;
  assign buck_current_ma_o = out_q.cur_ma;
  assign waiting_o         = out_q.waiting;

endmodule

[rtl/lacmc_checker.sv]
module lacmc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [3:0]                          charger_mode_o,
  input logic                                output_enable_o,
  input logic [lacmc_pkg::MvW-1:0]           buck_voltage_mv_o,
  input logic [lacmc_pkg::CurW-1:0]          buck_current_ma_o,
  input logic                                waiting_o
);
  import lacmc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(charger_mode_o) &&
      $stable(output_enable_o) && $stable(buck_voltage_mv_o) &&
      $stable(buck_current_ma_o) && $stable(waiting_o))
    else $error("result word changed while stalled");

  // input side only backs up behind a full result register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // load stays off in empty and fault modes
  a_load_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (charger_mode_o == MODE_EMPTY || charger_mode_o == MODE_DISC ||
      charger_mode_o == MODE_MAYBE || charger_mode_o == MODE_FAULTY)
      |-> !output_enable_o)
    else $error("load enabled in empty or fault mode");

  // commanded current never exceeds the cap
  a_cur_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> buck_current_ma_o <= MaxChgMa)
    else $error("buck current above cap");

endmodule

bind lead_acid_charge_mode_controller_unit lacmc_checker u_lacmc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .charger_mode_o    (charger_mode_o),
  .output_enable_o   (output_enable_o),
  .buck_voltage_mv_o (buck_voltage_mv_o),
  .buck_current_ma_o (buck_current_ma_o),
  .waiting_o         (waiting_o)
);
